@@ sv/pfe_pkg.sv @@
package pfe_pkg;

    localparam int MAX_FIELD = 62;
    localparam int FW = 6;
    localparam int NDIG_MAX = 24;
    localparam int NDW = 5;

    // divide a 20-bit slice by ten: (n * RECIP10) >> RECIP_SHIFT, exact below 2**22
    localparam logic [19:0] RECIP10 = 20'd838861;
    localparam int RECIP_SHIFT = 23;

    typedef enum logic [2:0]
    {
        PH_TEXT   = 3'd0,
        PH_FLAGS  = 3'd1,
        PH_WIDTH  = 3'd2,
        PH_PREC   = 3'd3,
        PH_PREFIX = 3'd4
    } phase_t;

    typedef enum logic [1:0]
    {
        RADIX_8  = 2'd0,
        RADIX_10 = 2'd1,
        RADIX_16 = 2'd2
    } radix_t;

    // command from controller to datapath
    typedef struct packed
    {
        logic        load;      // capture value and start digit extraction
        radix_t      radix;
        logic [63:0] value;     // magnitude already formed
        logic        pop;       // emit one digit, most significant first
    } dp_cmd_t;

    typedef struct packed
    {
        logic          busy;    // still extracting digits
        logic [NDW-1:0] ndig;
        logic [7:0]    digit_char;
    } dp_stat_t;

    function automatic logic [FW-1:0] add_digit(input logic [FW-1:0] acc, input logic [3:0] d);
        logic [10:0] v;
        begin
            v = 11'(acc) * 11'd10 + 11'(d);
            add_digit = (v > 11'(MAX_FIELD)) ? FW'(MAX_FIELD) : v[FW-1:0];
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        begin
            hex_char = (d < 4'd10) ? (8'h30 + 8'(d)) : (8'h57 + 8'(d));
        end
    endfunction

endpackage

@@ sv/printf_format_engine.sv @@
// integer printf formatter: one format character per input beat (tdata[7:0]),
// argument word in tdata[71:8]. a text beat's output beat is registered;
// directive characters give none but for %% and the conversion. a numeric
// conversion extracts its digits first, one digit a cycle for octal and hex
// and for decimal by long division by ten over four 16-bit slices per digit,
// while any sign goes out; then padding and then digits stream one beat a
// cycle while the output is not stalled. the next input beat is taken once
// the last digit has been pushed. tlast marks the last character of each
// input beat.
module printf_format_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // fmt_char[7:0], arg_value[71:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_char[7:0]
    output logic        m_tlast
);

    pfe_pkg::dp_cmd_t  cmd;
    pfe_pkg::dp_stat_t stat;

    pfe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .fmt_char  (s_tdata[7:0]),
        .arg_value (s_tdata[71:8]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

    pfe_datapath u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

@@ sv/pfe_datapath.sv @@
module pfe_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  pfe_pkg::dp_cmd_t  cmd,
    output pfe_pkg::dp_stat_t stat
);

    logic [63:0] val_reg, val_next;
    logic        busy_reg, busy_next;
    pfe_pkg::radix_t radix_reg, radix_next;
    logic [3:0]  dig_reg [pfe_pkg::NDIG_MAX];
    logic [3:0]  dig_next [pfe_pkg::NDIG_MAX];
    logic [pfe_pkg::NDW-1:0] nd_reg, nd_next;
    logic [3:0]  rem_reg, rem_next;   // running remainder of a decimal pass
    logic [1:0]  sub_reg, sub_next;   // 16-bit slice within a decimal pass
    logic [63:0] quot;
    logic [3:0]  rem;
    logic [19:0] num;
    logic [39:0] prod;
    logic [15:0] qch;
    logic [19:0] back;
    logic [3:0]  rch;
    logic [63:0] shifted;

    // octal and hex: one digit a cycle by shifting
    // decimal: long division by ten over four 16-bit slices, one slice a cycle,
    // each slice divided by reciprocal multiplication
    always_comb
    begin
        case (radix_reg)
            pfe_pkg::RADIX_8:
            begin
                quot = val_reg >> 3;
                rem  = {1'b0, val_reg[2:0]};
            end
            default:
            begin
                quot = val_reg >> 4;
                rem  = val_reg[3:0];
            end
        endcase
        num     = {rem_reg, val_reg[63:48]};
        prod    = 40'(num) * 40'(pfe_pkg::RECIP10);
        qch     = prod[pfe_pkg::RECIP_SHIFT +: 16];
        back    = num - 20'(qch) * 20'd10;
        rch     = back[3:0];
        shifted = {val_reg[47:0], qch};
    end

    always_comb
    begin
        val_next   = val_reg;
        busy_next  = busy_reg;
        radix_next = radix_reg;
        nd_next    = nd_reg;
        rem_next   = rem_reg;
        sub_next   = sub_reg;
        for (int i = 0; i < pfe_pkg::NDIG_MAX; i++)
        begin
            dig_next[i] = dig_reg[i];
        end
        if (cmd.load)
        begin
            val_next   = cmd.value;
            radix_next = cmd.radix;
            busy_next  = 1'b1;
            nd_next    = '0;
            rem_next   = '0;
            sub_next   = '0;
        end
        else if (busy_reg)
        begin
            if (radix_reg == pfe_pkg::RADIX_10)
            begin
                val_next = shifted;
                rem_next = rch;
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd3)
                begin
                    // last slice done: remainder is the digit, value the quotient
                    dig_next[nd_reg[pfe_pkg::NDW-1:0]] = rch;
                    nd_next  = nd_reg + 1'b1;
                    rem_next = '0;
                    if (shifted == 64'd0)
                    begin
                        busy_next = 1'b0;
                    end
                end
            end
            else
            begin
                dig_next[nd_reg[pfe_pkg::NDW-1:0]] = rem;
                nd_next  = nd_reg + 1'b1;
                val_next = quot;
                if (quot == 64'd0)
                begin
                    busy_next = 1'b0;
                end
            end
        end
        else if (cmd.pop && nd_reg != '0)
        begin
            nd_next = nd_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            nd_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            nd_reg   <= nd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        radix_reg <= radix_next;
        rem_reg   <= rem_next;
        sub_reg   <= sub_next;
        for (int i = 0; i < pfe_pkg::NDIG_MAX; i++)
        begin
            dig_reg[i] <= dig_next[i];
        end
    end

    logic [pfe_pkg::NDW-1:0] top_idx;
    assign top_idx = nd_reg - 1'b1;

    assign stat.busy       = busy_reg;
    assign stat.ndig       = nd_reg;
    assign stat.digit_char = pfe_pkg::hex_char(dig_reg[top_idx]);

endmodule

@@ sv/pfe_ctrl.sv @@
module pfe_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        fmt_char,
    input  logic [63:0]       arg_value,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        out_char,
    output logic              out_last,
    output pfe_pkg::dp_cmd_t  cmd,
    input  pfe_pkg::dp_stat_t stat
);

    typedef enum logic [4:0]
    {
        S_IDLE = 5'b00001,
        S_SIGN = 5'b00010,
        S_CONV = 5'b00100,
        S_PAD  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    pfe_pkg::phase_t ph_reg, ph_next;
    logic [3:0] flags_reg, flags_next;
    logic long_reg, long_next;
    logic [pfe_pkg::FW-1:0] fw_reg, fw_next, md_reg, md_next;
    logic [6:0] tot_reg, tot_next;
    logic neg_reg, neg_next;
    logic ov_reg, ov_next;
    logic [7:0] oc_reg, oc_next;
    logic ol_reg, ol_next;

    logic acc;
    logic outfree;
    logic [7:0] c;
    logic is_dig;
    logic is_pref;
    logic is_sgn;
    logic [63:0] v;
    logic [63:0] mag;
    logic [6:0] nd7;

    assign outfree = !ov_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && outfree;
    assign acc = s_tvalid && s_tready;
    assign c = fmt_char;
    assign is_dig = (c >= "0") && (c <= "9");
    assign is_pref = c == "F" || c == "N" || c == "h" || c == "l" || c == "L" ||
                     c == "z" || c == "t";
    assign is_sgn = c == "d" || c == "i";
    assign nd7 = 7'(stat.ndig);

    always_comb
    begin
        if (long_reg)
            v = arg_value;
        else if (is_sgn)
            v = {{32{arg_value[31]}}, arg_value[31:0]};
        else
            v = {32'd0, arg_value[31:0]};
        mag = (is_sgn && v[63]) ? (64'd0 - v) : v;
    end

    always_comb
    begin
        logic       push;
        logic [7:0] pc;
        logic       pl;
        pfe_pkg::phase_t eph;
        push = 1'b0;
        pc = '0;
        pl = 1'b0;
        state_next = state_reg;
        ph_next = ph_reg;
        flags_next = flags_reg;
        long_next = long_reg;
        fw_next = fw_reg;
        md_next = md_reg;
        tot_next = tot_reg;
        neg_next = neg_reg;
        cmd = '0;
        eph = ph_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (c == 8'd0)
                    begin
                        ph_next = pfe_pkg::PH_TEXT;
                    end
                    else
                    begin
                        // collapse fall-through phases
                        if (eph == pfe_pkg::PH_FLAGS && c != "%" && c != "-" && c != "+" &&
                            c != " " && c != "0")
                            eph = pfe_pkg::PH_WIDTH;
                        if (eph == pfe_pkg::PH_WIDTH && !is_dig && c != ".")
                            eph = pfe_pkg::PH_PREFIX;
                        if (eph == pfe_pkg::PH_PREC && !is_dig)
                            eph = pfe_pkg::PH_PREFIX;
                        ph_next = eph;
                        case (eph)
                            pfe_pkg::PH_FLAGS:
                            begin
                                if (c == "%")
                                begin
                                    push = 1'b1; pc = c; pl = 1'b1;
                                    ph_next = pfe_pkg::PH_TEXT;
                                end
                                else if (c == "-") flags_next[0] = 1'b1;
                                else if (c == "+") flags_next[1] = 1'b1;
                                else if (c == " ") flags_next[2] = 1'b1;
                                else flags_next[3] = 1'b1;
                            end
                            pfe_pkg::PH_WIDTH:
                            begin
                                if (is_dig)
                                    fw_next = pfe_pkg::add_digit(fw_reg, c[3:0]);
                                else
                                    ph_next = pfe_pkg::PH_PREC;
                            end
                            pfe_pkg::PH_PREC:
                            begin
                                md_next = pfe_pkg::add_digit(md_reg, c[3:0]);
                            end
                            pfe_pkg::PH_PREFIX:
                            begin
                                if (is_pref)
                                begin
                                    if (c == "L") long_next = 1'b1;
                                end
                                else
                                begin
                                    ph_next = pfe_pkg::PH_TEXT;
                                    if (c == "c")
                                    begin
                                        push = 1'b1; pc = arg_value[7:0]; pl = 1'b1;
                                    end
                                    else if (c == "o" || c == "x" || c == "X" || c == "p" ||
                                             c == "u" || is_sgn)
                                    begin
                                        if (c == "p")
                                        begin
                                            fw_next = pfe_pkg::FW'(8);
                                            flags_next[3] = 1'b1;
                                        end
                                        cmd.load = 1'b1;
                                        cmd.value = mag;
                                        cmd.radix = (c == "o") ? pfe_pkg::RADIX_8 :
                                                    (is_sgn || c == "u") ? pfe_pkg::RADIX_10 :
                                                    pfe_pkg::RADIX_16;
                                        neg_next = is_sgn && v[63];
                                        state_next = S_SIGN;
                                    end
                                end
                            end
                            default:
                            begin
                                ph_next = pfe_pkg::PH_TEXT;
                                if (c == "%")
                                begin
                                    ph_next = pfe_pkg::PH_FLAGS;
                                    flags_next = '0;
                                    long_next = 1'b0;
                                    fw_next = '0;
                                    md_next = '0;
                                end
                                else
                                begin
                                    push = 1'b1; pc = c; pl = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            S_SIGN:
            begin
                // datapath extracting digits in parallel
                if (!neg_reg)
                    state_next = S_CONV;
                else if (outfree)
                begin
                    push = 1'b1; pc = "-"; neg_next = 1'b0;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (!stat.busy)
                begin
                    tot_next = nd7;
                    state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                if (outfree)
                begin
                    if (tot_reg < 7'(fw_reg))
                    begin
                        push = 1'b1; pc = flags_reg[3] ? "0" : " ";
                        tot_next = tot_reg + 7'd1;
                    end
                    else if (tot_reg < 7'(md_reg))
                    begin
                        push = 1'b1; pc = "0";
                        tot_next = tot_reg + 7'd1;
                    end
                    else
                        state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (outfree)
                begin
                    push = 1'b1; pc = stat.digit_char;
                    pl = (stat.ndig == pfe_pkg::NDW'(1));
                    cmd.pop = 1'b1;
                    if (pl) state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // output register
        if (push)
        begin
            ov_next = 1'b1; oc_next = pc; ol_next = pl;
        end
        else
        begin
            ov_next = ov_reg && !m_tready; oc_next = oc_reg; ol_next = ol_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= pfe_pkg::PH_TEXT;
            flags_reg <= '0;
            long_reg  <= 1'b0;
            fw_reg    <= '0;
            md_reg    <= '0;
            ov_reg    <= 1'b0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            flags_reg <= flags_next;
            long_reg  <= long_next;
            fw_reg    <= fw_next;
            md_reg    <= md_next;
            ov_reg    <= ov_next;
            neg_reg   <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tot_reg <= tot_next;
        oc_reg  <= oc_next;
        ol_reg  <= ol_next;
    end

    assign m_tvalid = ov_reg;
    assign out_char = oc_reg;
    assign out_last = ol_reg;

endmodule

@@ sv/pfe_checker.sv @@
module pfe_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled beat changed");

    a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tlast))
        else $error("tlast changed under stall");

    a_no_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

endmodule

bind printf_format_engine pfe_checker u_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ bench/fmt_checker.sv @@
module fmt_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed
    {
        logic [7:0] ch;
        logic       last;
    } out_beat_t;

    localparam logic [3:0] FL_ZERO = 4'b1000;

    out_beat_t       chars_due[$];
    pfe_pkg::phase_t phase;
    logic [3:0]      flags;
    logic            long_mode;
    logic [5:0]      width_q;
    logic [5:0]      prec_q;

    function automatic int flag_pos(input logic [7:0] c);
        case (c)
            "-": return 0;
            "+": return 1;
            " ": return 2;
            "0": return 3;
            default: return -1;
        endcase
    endfunction

    function automatic logic [5:0] acc_digit(input logic [5:0] acc, input logic [7:0] c);
        int v;
        v = int'(acc) * 10 + int'(c - "0");
        return (v > pfe_pkg::MAX_FIELD) ? 6'(pfe_pkg::MAX_FIELD) : 6'(v);
    endfunction

    task automatic emit(inout out_beat_t q[$], input logic [7:0] c);
        if (q.size() < 64)
            q.push_back('{ch: c, last: 1'b0});
    endtask

    task automatic format_number(input logic [7:0] c, input logic [63:0] arg,
                                 inout out_beat_t q[$]);
        logic        sgn;
        logic [63:0] v;
        logic [7:0]  digs[$];
        logic [7:0]  pad;
        int          base;
        int          total;
        string       digit_set;
        digit_set = "0123456789abcdef";
        sgn = (c == "d" || c == "i");
        if (c == "c")
        begin
            emit(q, arg[7:0]);
            return;
        end
        if (c == "p")
        begin
            width_q = 6'd8;
            flags   = flags | FL_ZERO;
        end
        if (c == "o")
            base = 8;
        else if (c == "x" || c == "X" || c == "p")
            base = 16;
        else if (c == "u" || sgn)
            base = 10;
        else
            return;
        if (long_mode)
            v = arg;
        else if (sgn)
            v = {{32{arg[31]}}, arg[31:0]};
        else
            v = {32'b0, arg[31:0]};
        if (sgn && v[63])
        begin
            v = -v;
            emit(q, "-");
        end
        do
        begin
            digs.push_front(digit_set[int'(v % base)]);
            v = v / base;
        end
        while (v != 0);
        total = digs.size();
        pad = flags[3] ? "0" : " ";
        for (; total < width_q; total++)
            emit(q, pad);
        for (; total < prec_q; total++)
            emit(q, "0");
        foreach (digs[k])
            emit(q, digs[k]);
    endtask

    // one format character in, its output characters appended
    task automatic format_step(input logic [7:0] c, input logic [63:0] arg);
        out_beat_t q[$];
        int        fp;
        bit        done;
        done = 0;
        if (c == 8'd0)
        begin
            phase = pfe_pkg::PH_TEXT;
            return;
        end
        while (!done)
        begin
            case (phase)
                pfe_pkg::PH_FLAGS:
                begin
                    fp = flag_pos(c);
                    if (c == "%")
                    begin
                        emit(q, c);
                        phase = pfe_pkg::PH_TEXT;
                        done = 1;
                    end
                    else if (fp >= 0)
                    begin
                        flags[fp] = 1'b1;
                        done = 1;
                    end
                    else
                        phase = pfe_pkg::PH_WIDTH;
                end
                pfe_pkg::PH_WIDTH:
                begin
                    if (c >= "0" && c <= "9")
                    begin
                        width_q = acc_digit(width_q, c);
                        done = 1;
                    end
                    else if (c == ".")
                    begin
                        phase = pfe_pkg::PH_PREC;
                        done = 1;
                    end
                    else
                        phase = pfe_pkg::PH_PREFIX;
                end
                pfe_pkg::PH_PREC:
                begin
                    if (c >= "0" && c <= "9")
                    begin
                        prec_q = acc_digit(prec_q, c);
                        done = 1;
                    end
                    else
                        phase = pfe_pkg::PH_PREFIX;
                end
                pfe_pkg::PH_PREFIX:
                begin
                    if (c == "F" || c == "N" || c == "h" || c == "l" || c == "L" ||
                        c == "z" || c == "t")
                    begin
                        if (c == "L")
                            long_mode = 1'b1;
                    end
                    else
                    begin
                        format_number(c, arg, q);
                        phase = pfe_pkg::PH_TEXT;
                    end
                    done = 1;
                end
                default:
                begin
                    phase = pfe_pkg::PH_TEXT;
                    if (c == "%")
                    begin
                        phase     = pfe_pkg::PH_FLAGS;
                        flags     = '0;
                        long_mode = 1'b0;
                        width_q   = '0;
                        prec_q    = '0;
                    end
                    else
                        emit(q, c);
                    done = 1;
                end
            endcase
        end
        if (q.size() > 0)
            q[q.size()-1].last = 1'b1;
        foreach (q[k])
            chars_due.push_back(q[k]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t e;
        if (!rst_n)
        begin
            phase     <= pfe_pkg::PH_TEXT;
            flags     <= '0;
            long_mode <= 1'b0;
            width_q   <= '0;
            prec_q    <= '0;
            chars_due.delete();
            errors    <= 0;
        end
        else
        begin
            // output beat first: same-edge input can only add later entries
            if (m_tvalid && m_tready)
            begin
                if (chars_due.size() == 0)
                begin
                    $display("%0t: unexpected beat char %h last %b", $time, m_tdata, m_tlast);
                    errors <= errors + 1;
                end
                else
                begin
                    e = chars_due.pop_front();
                    if (e.ch !== m_tdata || e.last !== m_tlast)
                    begin
                        $display("%0t: expected char %h last %b, got char %h last %b",
                                 $time, e.ch, e.last, m_tdata, m_tlast);
                        errors <= errors + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                format_step(s_tdata[7:0], s_tdata[71:8]);
        end
    end

    assign pending = chars_due.size();

endmodule

@@ bench/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // fmt_char[7:0], arg_value[71:8]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_char[7:0]
    logic        m_tlast;
    int          errors;
    int          pending;
    int          cycles = 0;
    bit          calm;      // no idling on either side
    bit          fed;

    printf_format_engine dut (.*);

    fmt_checker chk (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // run limit: 64 chars per item with stalls, plus margin
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // sink side stalls about a third of the time except in the calm stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(99) >= 34);
    end

    logic [7:0]  fmt_q[$];
    logic [63:0] arg_q[$];

    function automatic logic [63:0] rnd64();
        case ($urandom_range(5))
            0: return 64'h8000_0000_0000_0000;
            1: return '1;
            2: return 64'($urandom_range(20));
            3: return {32'h0, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic push_str(input string s, input logic [63:0] a);
        foreach (s[k])
        begin
            fmt_q.push_back(s[k]);
            arg_q.push_back(a);
        end
    endtask

    // one directive with random flags, width, precision, prefix and conversion character
    task automatic push_directive();
        string flag_set;
        string conv_set;
        string prefix_set;
        string d;
        int    n;
        flag_set   = "-+ 0";
        conv_set   = "diuxXopc%sfgq";
        prefix_set = "FNhlLzt";
        d = "%";
        n = $urandom_range(2);
        repeat (n)
            d = {d, string'(flag_set[$urandom_range(3)])};
        if ($urandom_range(1))
            d = {d, $sformatf("%0d", $urandom_range($urandom_range(1) ? 12 : 99))};
        if ($urandom_range(2) == 0)
            d = {d, ".", $sformatf("%0d", $urandom_range($urandom_range(1) ? 12 : 99))};
        if ($urandom_range(1))
            d = {d, string'(prefix_set[$urandom_range(6)])};
        d = {d, string'(conv_set[$urandom_range(conv_set.len()-1)])};
        push_str(d, rnd64());
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        calm     = 1'b0;
        // directed: extremes, every conversion and the special cases
        push_str("A%%", 0);
        push_str("%d", 64'hFFFF_FFFF_8000_0000);
        push_str("%Ld", 64'h8000_0000_0000_0000);
        push_str("%062.62Lo", '1);
        push_str("%99.99u", 64'hFFFF_FFFF);
        push_str("%-+ 5x", 64'hABCDEF);
        push_str("%X%i%p%c%s", 64'h12345678_9ABCDE41);
        push_str("%.%", 0);
        push_str("%5", 0);
        fmt_q.push_back(8'h00);
        arg_q.push_back(0);
        fmt_q.push_back(8'hFF);
        arg_q.push_back('1);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // random: mostly directives with text and noise between
        while (fmt_q.size() < 160)
        begin
            case ($urandom_range(9))
                0: push_str(string'(8'($urandom_range(255))), rnd64());
                1, 2: push_str("ab", rnd64());
                default: push_directive();
            endcase
        end
        // first stretch: random idling on both sides, then a calm stretch, then random idling again
        foreach (fmt_q[k])
        begin
            if (k == 110)
                calm = 1'b1;
            if (k == 150)
                calm = 1'b0;
            while (!calm && $urandom_range(99) < 34)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {arg_q[k], fmt_q[k]};
            fed = 0;
            while (!fed)
            begin
                @(posedge clk);
                fed = s_tready;
            end
        end
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/pfe_pkg.sv
sv/pfe_datapath.sv
sv/pfe_ctrl.sv
sv/printf_format_engine.sv
sv/pfe_checker.sv
bench/fmt_checker.sv
bench/tb.sv
